// ===== rtl/core/bti_pkg.sv =====
// ----------------------------------------------------------------------------
// bti_pkg
// Request and result types and fixed codes of the bilinear table interpolator.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
package bti_pkg;

    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

    localparam int          FRAC_BITS = 16;
    localparam logic [16:0] RATIO_ONE = 17'h10000;
    localparam logic [4:0]  PC_RESET  = 5'd31;

    typedef struct packed {
        logic               cmd;
        logic [4:0]         row;
        logic [4:0]         col;
        logic signed [31:0] word;
        logic signed [31:0] pressure;
        logic signed [31:0] temperature;
    } t_in;

    typedef struct packed {
        logic signed [31:0] result_value;
        logic               in_range;
    } t_out;

endpackage
`default_nettype wire

// ===== rtl/core/bti_ratio_div.sv =====
// ----------------------------------------------------------------------------
// bti_ratio_div
// Saturated fractional ratio num/den in units of 2^-16, one quotient bit a cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module bti_ratio_div (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_start,
    input  wire logic signed [32:0] i_num,
    input  wire logic signed [32:0] i_den,
    output logic                    o_done,
    output logic [16:0]             o_ratio
);
    import bti_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_RUN,
        S_DONE
    } t_state;

    t_state      r_state;
    logic [33:0] r_rem;
    logic [32:0] r_den;
    logic [15:0] r_q;
    logic [4:0]  r_cnt;
    logic [16:0] r_ratio;

    logic [32:0] w_num_m;
    logic [32:0] w_den_m;
    logic        w_neg;
    logic [33:0] w_rem2;
    logic        w_ge;

    always_comb begin
        w_num_m = i_num[32] ? 33'(-i_num) : 33'(i_num);
        w_den_m = i_den[32] ? 33'(-i_den) : 33'(i_den);
        w_neg   = i_num[32] ^ i_den[32];
        w_rem2  = {r_rem[32:0], 1'b0};
        w_ge    = w_rem2 >= {1'b0, r_den};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (i_start) begin
                        r_rem <= {1'b0, w_num_m};
                        r_den <= w_den_m;
                        r_cnt <= 5'(FRAC_BITS);
                        r_q   <= '0;
                        if (i_den == '0 || i_num == '0 || w_neg) begin
                            r_ratio <= '0;
                            r_state <= S_DONE;
                        end else if (w_num_m >= w_den_m) begin
                            r_ratio <= RATIO_ONE;
                            r_state <= S_DONE;
                        end else begin
                            r_state <= S_RUN;
                        end
                    end
                end
                S_RUN: begin
                    r_rem <= w_ge ? 34'(w_rem2 - {1'b0, r_den}) : w_rem2;
                    r_q   <= {r_q[14:0], w_ge};
                    r_cnt <= r_cnt - 5'd1;
                    if (r_cnt == 5'd1) begin
                        r_ratio <= {1'b0, r_q[14:0], w_ge};
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_done  = (r_state == S_DONE);
    assign o_ratio = r_ratio;

endmodule
`default_nettype wire

// ===== rtl/core/bilinear_table_interpolator.sv =====
// ----------------------------------------------------------------------------
// bilinear_table_interpolator
// Two-axis table store with binary bracket search and bilinear blending.
// ----------------------------------------------------------------------------
//  channel  direction  handshake                 payload
//  in       input      i_in_valid / o_in_stall   i_in_data  (bti_pkg::t_in)
//  out      output     o_out_valid / i_out_stall o_out_data (bti_pkg::t_out)
//  cfg      input      i_cfg_valid / o_cfg_ready i_cfg_data (point_count)
//
//  A write request yields no result. A query runs four range reads, two
//  bracket searches (a read and a compare state a step), two ratio divisions
//  and three blends on one shared multiplier, or stops after the range reads
//  for an out-of-range point; the table memory's one read port sets the read
//  pace. Reset is synchronous; the table is not cleared. A stalled result
//  holds in the output register while the next request is accepted.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module bilinear_table_interpolator #(
    parameter int MAX_POINTS = 31
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_in_valid,
    input  wire bti_pkg::t_in  i_in_data,
    output logic               o_in_stall,
    output logic               o_out_valid,
    output bti_pkg::t_out      o_out_data,
    input  wire logic          i_out_stall,
    input  wire logic          i_cfg_valid,
    input  wire logic [4:0]    i_cfg_data,
    output logic               o_cfg_ready
);
    import bti_pkg::*;

    localparam int DIM   = MAX_POINTS + 1;
    localparam int DEPTH = DIM * DIM;
    localparam int AW    = $clog2(DEPTH);
    localparam int IW    = $clog2(DIM);

    typedef enum logic [4:0] {
        S_IDLE, S_LO_P, S_HI_P, S_LO_T, S_HI_T, S_SINIT, S_SRCH, S_SCMP,
        S_RA, S_RB, S_RC, S_DIV, S_C0, S_C1, S_C2, S_C3, S_C4,
        S_BLD, S_BMUL, S_BSUM, S_DONE
    } t_state;

    t_state             r_state;
    logic [4:0]         r_point_count;
    logic [31:0]        r_mem [DEPTH];
    logic signed [31:0] r_rdata;
    logic signed [31:0] r_p, r_t;
    logic [IW-1:0]      r_n, r_lo, r_hi, r_mid, r_ip, r_it;
    logic               r_axis;
    logic signed [31:0] r_a0;
    logic [16:0]        r_rp, r_rt;
    logic signed [31:0] r_v00, r_v10, r_v01, r_v11, r_blo, r_bhi, r_base;
    logic signed [32:0] r_ma;
    logic signed [17:0] r_mb;
    logic signed [50:0] r_prod;
    logic [1:0]         r_bsel;
    logic signed [32:0] r_num, r_den;
    logic               r_div_start;
    logic               r_out_valid;
    t_out               r_out;

    logic [AW-1:0]      w_rd_addr;
    logic [IW-1:0]      w_n;
    logic [IW-1:0]      w_mid;
    logic [IW-1:0]      w_idx;
    logic signed [31:0] w_x;
    logic signed [51:0] w_sum;
    logic               w_div_done;
    logic [16:0]        w_ratio;
    logic               w_in_acc;
    logic               w_wr_ok;
    int                 w_pc;

    function automatic logic [AW-1:0] f_addr(input logic [IW-1:0] r, input logic [IW-1:0] c);
        return AW'(int'(r) * DIM + int'(c));
    endfunction

    always_comb begin
        w_pc = int'(r_point_count);
        if (w_pc < 2) w_n = IW'(2);
        else if (w_pc > MAX_POINTS) w_n = IW'(MAX_POINTS);
        else w_n = IW'(w_pc);
        w_mid    = IW'((int'(r_lo) + int'(r_hi) + 1) / 2);
        w_idx    = r_axis ? r_it : r_ip;
        w_x      = r_axis ? r_t : r_p;
        w_sum    = (52'(r_base) <<< FRAC_BITS) + 52'(r_prod) + 52'(32768);
        w_in_acc = i_in_valid && !o_in_stall;
        w_wr_ok  = int'(i_in_data.row) <= MAX_POINTS && int'(i_in_data.col) <= MAX_POINTS;
    end

    always_comb begin
        w_rd_addr = '0;
        unique case (r_state)
            S_LO_P: w_rd_addr = f_addr(IW'(1), '0);
            S_HI_P: w_rd_addr = f_addr(r_n, '0);
            S_LO_T: w_rd_addr = f_addr('0, IW'(1));
            S_HI_T: w_rd_addr = f_addr('0, r_n);
            S_SRCH: w_rd_addr = r_axis ? f_addr('0, w_mid) : f_addr(w_mid, '0);
            S_RA:   w_rd_addr = r_axis ? f_addr('0, w_idx) : f_addr(w_idx, '0);
            S_RB:   w_rd_addr = r_axis ? f_addr('0, IW'(w_idx + 1'b1))
                                       : f_addr(IW'(w_idx + 1'b1), '0);
            S_C0:   w_rd_addr = f_addr(r_ip, r_it);
            S_C1:   w_rd_addr = f_addr(IW'(r_ip + 1'b1), r_it);
            S_C2:   w_rd_addr = f_addr(r_ip, IW'(r_it + 1'b1));
            S_C3:   w_rd_addr = f_addr(IW'(r_ip + 1'b1), IW'(r_it + 1'b1));
            default: w_rd_addr = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc && i_in_data.cmd == CMD_WRITE && w_wr_ok) begin
            r_mem[f_addr(IW'(int'(i_in_data.row)), IW'(int'(i_in_data.col)))] <= i_in_data.word;
        end
        r_rdata <= r_mem[w_rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_point_count <= PC_RESET;
        end else if (i_cfg_valid) begin
            r_point_count <= i_cfg_data;
        end
    end

    bti_ratio_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_div_start),
        .i_num   (r_num),
        .i_den   (r_den),
        .o_done  (w_div_done),
        .o_ratio (w_ratio)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_div_start <= 1'b0;
        end else begin
            r_div_start <= 1'b0;
            if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (w_in_acc && i_in_data.cmd == CMD_QUERY) begin
                        r_p     <= i_in_data.pressure;
                        r_t     <= i_in_data.temperature;
                        r_n     <= w_n;
                        r_state <= S_LO_P;
                    end
                end
                S_LO_P: r_state <= S_HI_P;
                S_HI_P: begin
                    r_state <= (r_p < r_rdata) ? S_DONE : S_LO_T;
                    r_out   <= '0;
                end
                S_LO_T: r_state <= (r_p >= r_rdata) ? S_DONE : S_HI_T;
                S_HI_T: r_state <= (r_t < r_rdata) ? S_DONE : S_SINIT;
                S_SINIT: begin
                    r_lo    <= IW'(1);
                    r_hi    <= IW'(r_n - 1'b1);
                    r_axis  <= 1'b0;
                    r_state <= (r_t >= r_rdata) ? S_DONE : S_SRCH;
                end
                S_SRCH: begin
                    if (r_lo < r_hi) begin
                        r_mid   <= w_mid;
                        r_state <= S_SCMP;
                    end else if (!r_axis) begin
                        r_ip   <= r_lo;
                        r_lo   <= IW'(1);
                        r_hi   <= IW'(r_n - 1'b1);
                        r_axis <= 1'b1;
                    end else begin
                        r_it    <= r_lo;
                        r_axis  <= 1'b0;
                        r_state <= S_RA;
                    end
                end
                S_SCMP: begin
                    if (r_rdata <= w_x) r_lo <= r_mid;
                    else r_hi <= IW'(r_mid - 1'b1);
                    r_state <= S_SRCH;
                end
                S_RA: r_state <= S_RB;
                S_RB: begin
                    r_a0    <= r_rdata;
                    r_state <= S_RC;
                end
                S_RC: begin
                    r_num       <= 33'(w_x) - 33'(r_a0);
                    r_den       <= 33'(r_rdata) - 33'(r_a0);
                    r_div_start <= 1'b1;
                    r_state     <= S_DIV;
                end
                S_DIV: begin
                    if (w_div_done) begin
                        if (!r_axis) begin
                            r_rp    <= w_ratio;
                            r_axis  <= 1'b1;
                            r_state <= S_RA;
                        end else begin
                            r_rt    <= w_ratio;
                            r_state <= S_C0;
                        end
                    end
                end
                S_C0: r_state <= S_C1;
                S_C1: begin
                    r_v00   <= r_rdata;
                    r_state <= S_C2;
                end
                S_C2: begin
                    r_v10   <= r_rdata;
                    r_state <= S_C3;
                end
                S_C3: begin
                    r_v01   <= r_rdata;
                    r_state <= S_C4;
                end
                S_C4: begin
                    r_v11   <= r_rdata;
                    r_bsel  <= 2'd0;
                    r_state <= S_BLD;
                end
                S_BLD: begin
                    case (r_bsel)
                        2'd0: begin
                            r_ma   <= 33'(r_v10) - 33'(r_v00);
                            r_mb   <= 18'(r_rp);
                            r_base <= r_v00;
                        end
                        2'd1: begin
                            r_ma   <= 33'(r_v11) - 33'(r_v01);
                            r_mb   <= 18'(r_rp);
                            r_base <= r_v01;
                        end
                        default: begin
                            r_ma   <= 33'(r_bhi) - 33'(r_blo);
                            r_mb   <= 18'(r_rt);
                            r_base <= r_blo;
                        end
                    endcase
                    r_state <= S_BMUL;
                end
                S_BMUL: begin
                    r_prod  <= r_ma * r_mb;
                    r_state <= S_BSUM;
                end
                S_BSUM: begin
                    case (r_bsel)
                        2'd0: r_blo <= w_sum[47:16];
                        2'd1: r_bhi <= w_sum[47:16];
                        default: begin
                            r_out.result_value <= w_sum[47:16];
                            r_out.in_range     <= 1'b1;
                        end
                    endcase
                    r_bsel  <= r_bsel + 2'd1;
                    r_state <= (r_bsel == 2'd2) ? S_DONE : S_BLD;
                end
                S_DONE: begin
                    if (!r_out_valid || !i_out_stall) begin
                        o_out_data  <= r_out;
                        r_out_valid <= 1'b1;
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_cfg_ready = 1'b1;

endmodule
`default_nettype wire

// ===== rtl/core/bti_checker.sv =====
// ----------------------------------------------------------------------------
// bti_checker
// Port-level checks of the bilinear table interpolator, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module bti_checker (
    input wire logic          i_clk,
    input wire logic          i_rst_n,
    input wire logic          i_in_valid,
    input wire bti_pkg::t_in  i_in_data,
    input wire logic          o_in_stall,
    input wire logic          o_out_valid,
    input wire bti_pkg::t_out o_out_data,
    input wire logic          i_out_stall
);
    import bti_pkg::*;

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_data))
        else $error("stalled result changed");

    a_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_data.in_range |-> o_out_data.result_value == 32'sd0)
        else $error("out of range result not zero");

    a_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall && i_in_data.cmd == CMD_WRITE |=> !o_in_stall)
        else $error("write request held the input");

    a_query: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall && i_in_data.cmd == CMD_QUERY |=> o_in_stall)
        else $error("query request not held");

    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid && !o_in_stall)
        else $error("reset left activity");

endmodule

bind bilinear_table_interpolator bti_checker u_bti_checker (.*);
`default_nettype wire
